[rtl/core/dfs_topo_pkg.sv]
`default_nettype none

package dfs_topo_pkg;

    localparam int MAX_NODES  = 16;
    localparam int NODE_LIMIT = (MAX_NODES < 16) ? MAX_NODES : 16;

    // fixed field widths
    localparam int NODE_W = 4;
    localparam int MASK_W = 16;
    localparam int CFG_W  = 5;

    // derived widths
    localparam int IDX_W   = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
    localparam int DEPTH_W = $clog2(NODE_LIMIT + 1);

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(16);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROOT,
        ST_WALK,
        ST_EMIT
    } dfs_state_t;

    typedef struct packed {
        logic load_row;
        logic clear;
        logic scan;
        logic start_walk;
        logic step;
        logic emit_init;
        logic emit_load;
    } dfs_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic root_avail;
        logic walk_done;
        logic emit_left;
        logic emit_one;
        logic out_free;
    } dfs_status_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [DEPTH_W-1:0] next;
    } dfs_frame_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [NODE_W-1:0] lowest_set(input logic [NODE_LIMIT-1:0] v);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int j = NODE_LIMIT - 1; j >= 0; j--)
        begin
            if (v[j])
            begin
                idx = NODE_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[rtl/core/dfs_topo_ctrl.sv]
`default_nettype none

module dfs_topo_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   last_row,
    input  wire dfs_topo_pkg::dfs_status_t status,
    output logic                        in_stall,
    output dfs_topo_pkg::dfs_cmd_t      cmd
);

    dfs_topo_pkg::dfs_state_t state_reg;
    dfs_topo_pkg::dfs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfs_topo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            dfs_topo_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_row = 1'b1;
                    if (last_row)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = dfs_topo_pkg::ST_SCAN;
                    end
                end
            end
            dfs_topo_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = dfs_topo_pkg::ST_ROOT;
                end
            end
            dfs_topo_pkg::ST_ROOT:
            begin
                if (status.root_avail)
                begin
                    cmd.start_walk = 1'b1;
                    state_next     = dfs_topo_pkg::ST_WALK;
                end
                else
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = dfs_topo_pkg::ST_EMIT;
                end
            end
            dfs_topo_pkg::ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = dfs_topo_pkg::ST_ROOT;
                end
            end
            dfs_topo_pkg::ST_EMIT:
            begin
                if (!status.emit_left)
                begin
                    state_next = dfs_topo_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_one)
                    begin
                        state_next = dfs_topo_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dfs_topo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/dfs_topo_dp.sv]
`default_nettype none

module dfs_topo_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [dfs_topo_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic [dfs_topo_pkg::NODE_W-1:0]       row_index,
    input  wire logic [dfs_topo_pkg::MASK_W-1:0]       child_mask,
    input  wire dfs_topo_pkg::dfs_cmd_t                cmd,
    input  wire logic                                  out_stall,
    output dfs_topo_pkg::dfs_status_t                  status,
    output logic                                       out_valid,
    output logic [dfs_topo_pkg::NODE_W-1:0]            node_index,
    output logic                                       is_last,
    output logic                                       cycle_found
);

    localparam int NL  = dfs_topo_pkg::NODE_LIMIT;
    localparam int NW  = dfs_topo_pkg::NODE_W;
    localparam int IW  = dfs_topo_pkg::IDX_W;
    localparam int DW  = dfs_topo_pkg::DEPTH_W;
    localparam int CW  = dfs_topo_pkg::CFG_W;

    logic [CW-1:0]  node_count_reg;

    logic [NL-1:0]  adj_reg [NL];
    logic [NL-1:0]  visited_reg;
    logic [NL-1:0]  on_path_reg;
    logic [NL-1:0]  incoming_reg;
    logic           cycle_reg;
    logic [IW-1:0]  row_ctr_reg;

    logic [NW-1:0]  top_node_reg;
    logic [DW-1:0]  top_next_reg;
    logic [DW-1:0]  depth_reg;
    dfs_topo_pkg::dfs_frame_t stack_reg [NL];

    logic [NW-1:0]  order_reg [NL];
    logic [DW-1:0]  count_reg;
    logic [DW-1:0]  emit_ptr_reg;

    logic           out_valid_reg;
    logic [NW-1:0]  out_node_reg;
    logic           out_last_reg;
    logic           out_cycle_reg;

    logic [DW-1:0]  n_active;
    logic [NL-1:0]  use_mask;
    logic [NL-1:0]  above_mask;
    logic [NL-1:0]  child_cand;
    logic           child_found;
    logic [NW-1:0]  child;
    logic [IW-1:0]  child_idx;
    logic [IW-1:0]  top_idx;
    logic [NL-1:0]  root_cand1;
    logic [NL-1:0]  root_cand2;
    logic [NW-1:0]  root;
    logic [DW-1:0]  depth_m1;
    logic [DW-1:0]  depth_m2;
    logic [DW-1:0]  emit_m1;
    logic [DW-1:0]  n_m1;

    // node count clamped into one .. node limit
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_active = DW'(1);
        end
        else if (CW'(node_count_reg) > CW'(NL))
        begin
            n_active = DW'(NL);
        end
        else
        begin
            n_active = DW'(node_count_reg);
        end
    end

    always_comb
    begin
        for (int j = 0; j < NL; j++)
        begin
            use_mask[j]   = (DW'(j) < n_active);
            above_mask[j] = (DW'(j) >= top_next_reg);
        end
    end

    assign top_idx     = top_node_reg[IW-1:0];
    assign child_cand  = adj_reg[top_idx] & use_mask & above_mask;
    assign child_found = |child_cand;
    assign child       = dfs_topo_pkg::lowest_set(child_cand);
    assign child_idx   = child[IW-1:0];

    assign root_cand1 = ~visited_reg & ~incoming_reg & use_mask;
    assign root_cand2 = ~visited_reg & use_mask;
    assign root       = (|root_cand1) ? dfs_topo_pkg::lowest_set(root_cand1)
                                      : dfs_topo_pkg::lowest_set(root_cand2);

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign emit_m1  = emit_ptr_reg - DW'(1);
    assign n_m1     = n_active - DW'(1);

    assign status.scan_last  = (DW'(row_ctr_reg) == n_m1);
    assign status.root_avail = |root_cand2;
    assign status.walk_done  = !child_found && (depth_reg == DW'(1));
    assign status.emit_left  = (emit_ptr_reg != '0);
    assign status.emit_one   = (emit_ptr_reg == DW'(1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= dfs_topo_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // adjacency rows, rows past the node limit are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.load_row && ((NW + 1)'(row_index) < (NW + 1)'(NL)))
        begin
            adj_reg[row_index[IW-1:0]] <= child_mask[NL-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            on_path_reg  <= '0;
            incoming_reg <= '0;
            cycle_reg    <= 1'b0;
            row_ctr_reg  <= '0;
            depth_reg    <= '0;
            count_reg    <= '0;
            emit_ptr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            visited_reg  <= '0;
            on_path_reg  <= '0;
            incoming_reg <= '0;
            cycle_reg    <= 1'b0;
            row_ctr_reg  <= '0;
            depth_reg    <= '0;
            count_reg    <= '0;
        end
        else if (cmd.scan)
        begin
            incoming_reg <= incoming_reg | (adj_reg[row_ctr_reg] & use_mask);
            row_ctr_reg  <= row_ctr_reg + IW'(1);
        end
        else if (cmd.start_walk)
        begin
            visited_reg[root[IW-1:0]] <= 1'b1;
            on_path_reg[root[IW-1:0]] <= 1'b1;
            depth_reg                 <= DW'(1);
        end
        else if (cmd.step)
        begin
            if (child_found)
            begin
                if (on_path_reg[child_idx])
                begin
                    // back edge
                    cycle_reg <= 1'b1;
                end
                else if (!visited_reg[child_idx] && (depth_reg < DW'(NL)))
                begin
                    visited_reg[child_idx] <= 1'b1;
                    on_path_reg[child_idx] <= 1'b1;
                    depth_reg              <= depth_reg + DW'(1);
                end
            end
            else
            begin
                on_path_reg[top_idx] <= 1'b0;
                depth_reg            <= depth_m1;
                if (count_reg < DW'(NL))
                begin
                    count_reg <= count_reg + DW'(1);
                end
            end
        end
        else if (cmd.emit_init)
        begin
            emit_ptr_reg <= count_reg;
        end
        else if (cmd.emit_load)
        begin
            emit_ptr_reg <= emit_m1;
        end
    end

    // top of the walk stack lives in registers, frames below it in the array
    always_ff @(posedge clk)
    begin
        if (cmd.start_walk)
        begin
            top_node_reg <= root;
            top_next_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (child_found)
            begin
                if (!on_path_reg[child_idx] && !visited_reg[child_idx]
                    && (depth_reg < DW'(NL)))
                begin
                    stack_reg[depth_m1[IW-1:0]] <= '{node: top_node_reg,
                                                     next: DW'(child) + DW'(1)};
                    top_node_reg <= child;
                    top_next_reg <= '0;
                end
                else
                begin
                    top_next_reg <= DW'(child) + DW'(1);
                end
            end
            else
            begin
                if (count_reg < DW'(NL))
                begin
                    order_reg[count_reg[IW-1:0]] <= top_node_reg;
                end
                if (depth_reg > DW'(1))
                begin
                    top_node_reg <= stack_reg[depth_m2[IW-1:0]].node;
                    top_next_reg <= stack_reg[depth_m2[IW-1:0]].next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // post-order read back from the end gives the topological order
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_node_reg  <= order_reg[emit_m1[IW-1:0]];
            out_last_reg  <= (emit_ptr_reg == DW'(1));
            out_cycle_reg <= cycle_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign node_index  = out_node_reg;
    assign is_last     = out_last_reg;
    assign cycle_found = out_cycle_reg;

endmodule

`default_nettype wire

[rtl/core/dfs_topological_sort.sv]
`default_nettype none

// Depth-first topological sort of a graph of up to 16 nodes. Adjacency rows
// are taken one item per cycle; the item flagged last_row stores its row and
// starts the sort, and in_stall stays high until the final result is loaded
// into the output register. The sort first scans the rows to gather the
// parent set, then picks roots one at a time until none is left, walking the
// stack from each root with one step for every edge seen and one for every
// node finished. Results then leave one per cycle, reversed post-order, unless
// out_stall holds them. cycle_found is set on every result of a sort that met
// a back edge. node_count is to be written through cfg_write/cfg_data only
// while the block is idle; the block does not enforce this. It is clamped
// into 1..16.
module dfs_topological_sort (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [dfs_topo_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dfs_topo_pkg::NODE_W-1:0]  row_index,
    input  wire logic [dfs_topo_pkg::MASK_W-1:0]  child_mask,
    input  wire logic                             last_row,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [dfs_topo_pkg::NODE_W-1:0]       node_index,
    output logic                                  is_last,
    output logic                                  cycle_found
);

    dfs_topo_pkg::dfs_cmd_t    cmd;
    dfs_topo_pkg::dfs_status_t status;

    dfs_topo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_row (last_row),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    dfs_topo_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .row_index   (row_index),
        .child_mask  (child_mask),
        .cmd         (cmd),
        .out_stall   (out_stall),
        .status      (status),
        .out_valid   (out_valid),
        .node_index  (node_index),
        .is_last     (is_last),
        .cycle_found (cycle_found)
    );

endmodule

`default_nettype wire

[rtl/core/dfs_topo_chk.sv]
`default_nettype none

module dfs_topo_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic                             last_row,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [dfs_topo_pkg::NODE_W-1:0]  node_index,
    input wire logic                             is_last,
    input wire logic                             cycle_found
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(node_index) && $stable(is_last))
    else $error("stalled result item changed");

    // no new row while a sort still has results to give
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> in_stall)
    else $error("input taken in the middle of an order");

    // results of one sort follow back to back with one cycle flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |=> out_valid && (cycle_found == $past(cycle_found)))
    else $error("order broken or cycle flag changed within one sort");

    // the final row starts the sort, so input closes at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_row |=> in_stall)
    else $error("input still open after the final row");

endmodule

bind dfs_topological_sort dfs_topo_chk u_dfs_topo_chk (.*);

`default_nettype wire
